/* hdl/bba_pkg.sv */
package bba_pkg;

  // Bitmap word geometry: one memory word holds this many allocation units
  localparam int WORD_BITS = 16;
  localparam int WORD_LOG  = 4;

  // Input action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_IN_USE   = 3'd2,
    ST_NO_SPACE = 3'd3,
    ST_UNKNOWN  = 3'd4
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;        // capture input beat, read tag table
    logic    clr_step;    // clear one bitmap word
    logic    free_setup;  // take block from tag table
    logic    scan_start;  // begin bitmap scan at word 0
    logic    scan_step;   // evaluate one word, fetch next
    logic    mark_read;   // fetch first word of the block
    logic    mark_write;  // write one word of the block
    logic    tag_commit;  // update tag table
    logic    out_load;    // load the result register
    status_t out_code;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic    clr_done;
    status_t chk_code;
    logic    is_free;
    logic    fits;
    logic    scan_found;
    logic    scan_fail;
    logic    mark_last;
  } dp_stat_t;

endpackage

/* hdl/bba_datapath.sv */
module bba_datapath #(
  parameter int POOL_MAX  = 256,
  parameter int TAG_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bba_pkg::ctrl_cmd_t  cmd,
  output bba_pkg::dp_stat_t   stat,
  input  logic                in_action,
  input  logic [3:0]          in_tag,
  input  logic [8:0]          in_request,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_data,
  output bba_pkg::status_t    out_status,
  output logic [7:0]          out_start_unit,
  output logic [8:0]          out_block_units
);

  localparam int WB    = bba_pkg::WORD_BITS;
  localparam int WL    = bba_pkg::WORD_LOG;
  localparam int NW    = (POOL_MAX + WB - 1) / WB;
  localparam int WA_W  = (NW > 1) ? $clog2(NW) : 1;
  localparam int WC_W  = $clog2(NW + 1);
  localparam int POS_W = $clog2(POOL_MAX + 1);
  localparam int TAG_W = $clog2(TAG_COUNT);
  localparam int A_W   = ((POS_W > 10) ? POS_W : 10) + 1;

  // Configuration
  logic [8:0] pool_r;

  // Bitmap memory
  logic [WB-1:0]   bmap [NW];
  logic [WB-1:0]   rd_q_r;
  logic [WC_W-1:0] ra_w;
  logic            we;
  logic [WC_W-1:0] wa_w;
  logic [WB-1:0]   wd;
  logic [WC_W-1:0] clr_w_r;

  // Captured item
  logic       act_r;
  logic [3:0] tag_r;
  logic [8:0] req_r;

  // Tag table
  logic [TAG_COUNT-1:0] tag_valid_r;
  logic [POS_W-1:0]     tag_start_mem [TAG_COUNT];
  logic [3:0]           tag_log_mem   [TAG_COUNT];
  logic [POS_W-1:0]     tq_start_r;
  logic [3:0]           tq_log_r;
  logic                 in_tag_ok;
  logic                 tag_ok;
  logic [TAG_W-1:0]     tidx;
  logic                 tv;
  bba_pkg::status_t     chk_code;

  // Scan and mark state
  logic [WC_W-1:0]  rd_w_r;
  logic [WC_W-1:0]  ev_w_r;
  logic             ok_r;
  logic [POS_W-1:0] pos_r;
  logic [3:0]       lg_r;
  logic [WC_W-1:0]  mk_w_r;
  logic [A_W-1:0]   mk_cnt_r;

  // Result register
  bba_pkg::status_t out_status_r;
  logic [7:0]       out_start_r;
  logic [8:0]       out_len_r;

  // Scan evaluation
  logic [3:0]     lg_a;
  logic [A_W-1:0] lim, len_a, bwm1, wv, base, pos_big, found_pos;
  logic           big, first, last, room_out, ok_nxt, found_big, hit;
  logic [WL-1:0]  sel;

  // Mark evaluation
  logic [A_W-1:0] pos_a, mk_len, mk_bwm1;
  logic           mk_big;
  logic [WB-1:0]  smask;

  // Tag lookups
  assign in_tag_ok = (32'(in_tag) < TAG_COUNT);
  assign tag_ok    = (32'(tag_r) < TAG_COUNT);
  assign tidx      = TAG_W'(tag_r);
  assign tv        = tag_ok && tag_valid_r[tidx];

  // Pool bound, saturated at the bitmap size
  assign lim = (A_W'(pool_r) > A_W'(POOL_MAX)) ? A_W'(POOL_MAX) : A_W'(pool_r);

  // Rounded size of the request
  always_comb begin
    lg_a = 4'd9;
    for (int l = 9; l >= 0; l--) begin
      if ((11'(1) << l) >= 11'(req_r)) lg_a = 4'(l);
    end
  end

  assign len_a = A_W'(1) << lg_a;
  assign big   = (lg_a >= 4'(WL));
  assign bwm1  = big ? ((len_a >> WL) - A_W'(1)) : '0;
  assign wv    = A_W'(ev_w_r);
  assign base  = wv << WL;

  // Multi-word blocks: all words of an aligned group must be empty
  assign first     = !big || ((wv & bwm1) == '0);
  assign last      = !big || ((wv & bwm1) == bwm1);
  assign room_out  = first && ((base + len_a) > lim);
  assign ok_nxt    = (first ? 1'b1 : ok_r) && (rd_q_r == '0);
  assign found_big = last && ok_nxt && !room_out;
  assign pos_big   = (wv & ~bwm1) << WL;

  // Sub-word blocks: lowest aligned free run inside the current word
  always_comb begin
    logic seg_used;
    logic cand;
    hit = 1'b0;
    sel = '0;
    for (int o = WB - 1; o >= 0; o--) begin
      seg_used = 1'b0;
      for (int k = 0; k < 8; k++) begin
        if ((A_W'(k) < len_a) && (o + k < WB)) seg_used = seg_used | rd_q_r[(o + k) % WB];
      end
      cand = ((A_W'(o) & (len_a - A_W'(1))) == '0) && !seg_used &&
             ((base + A_W'(o) + len_a) <= lim);
      if (cand) begin
        hit = 1'b1;
        sel = WL'(o);
      end
    end
  end

  assign found_pos = big ? pos_big : (base + A_W'(sel));

  // Mark geometry from the held block
  assign pos_a   = A_W'(pos_r);
  assign mk_len  = A_W'(1) << lg_r;
  assign mk_big  = (lg_r >= 4'(WL));
  assign mk_bwm1 = mk_big ? ((mk_len >> WL) - A_W'(1)) : '0;

  always_comb begin
    for (int b = 0; b < WB; b++) begin
      smask[b] = (A_W'(b) >= A_W'(pos_a[WL-1:0])) &&
                 (A_W'(b) < (A_W'(pos_a[WL-1:0]) + mk_len));
    end
  end

  // Bitmap port selection
  always_comb begin
    ra_w = rd_w_r;
    if (cmd.scan_start) ra_w = '0;
    else if (cmd.mark_read) ra_w = WC_W'(pos_a >> WL);
    we   = 1'b0;
    wa_w = mk_w_r;
    wd   = '0;
    if (cmd.clr_step) begin
      we   = 1'b1;
      wa_w = clr_w_r;
    end else if (cmd.mark_write) begin
      we = 1'b1;
      if (mk_big) wd = (act_r == bba_pkg::ACT_ALLOC) ? '1 : '0;
      else if (act_r == bba_pkg::ACT_ALLOC) wd = rd_q_r | smask;
      else wd = rd_q_r & ~smask;
    end
  end

  always_ff @(posedge clk) begin
    if (we) bmap[wa_w[WA_W-1:0]] <= wd;
    rd_q_r <= bmap[ra_w[WA_W-1:0]];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r      <= 9'd256;
      clr_w_r     <= '0;
      tag_valid_r <= '0;
    end else begin
      if (cfg_we) pool_r <= cfg_data;
      if (cmd.clr_step) clr_w_r <= clr_w_r + WC_W'(1);
      if (cmd.tag_commit) tag_valid_r[tidx] <= (act_r == bba_pkg::ACT_ALLOC);
    end
  end

  // Tag table memory
  always_ff @(posedge clk) begin
    if (cmd.tag_commit && (act_r == bba_pkg::ACT_ALLOC)) begin
      tag_start_mem[tidx] <= pos_r;
      tag_log_mem[tidx]   <= lg_r;
    end
    if (cmd.load && in_tag_ok) begin
      tq_start_r <= tag_start_mem[TAG_W'(in_tag)];
      tq_log_r   <= tag_log_mem[TAG_W'(in_tag)];
    end
  end

  // Item capture, scan and mark bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      tag_r <= in_tag;
      req_r <= in_request;
    end
    if (cmd.scan_start) begin
      rd_w_r <= WC_W'(1);
      ev_w_r <= '0;
      ok_r   <= 1'b1;
    end else if (cmd.scan_step) begin
      rd_w_r <= rd_w_r + WC_W'(1);
      ev_w_r <= rd_w_r;
      ok_r   <= ok_nxt;
      if (stat.scan_found) begin
        pos_r <= POS_W'(found_pos);
        lg_r  <= lg_a;
      end
    end
    if (cmd.free_setup) begin
      pos_r <= tq_start_r;
      lg_r  <= tq_log_r;
    end
    if (cmd.mark_read) begin
      mk_w_r   <= WC_W'(pos_a >> WL);
      mk_cnt_r <= mk_bwm1;
    end else if (cmd.mark_write) begin
      mk_w_r   <= mk_w_r + WC_W'(1);
      mk_cnt_r <= mk_cnt_r - A_W'(1);
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_code;
      out_start_r  <= (cmd.out_code == bba_pkg::ST_OK) ? 8'(pos_r) : 8'd0;
      out_len_r    <= (cmd.out_code == bba_pkg::ST_OK) ? 9'(mk_len) : 9'd0;
    end
  end

  // Item checks in priority order
  always_comb begin
    chk_code = bba_pkg::ST_OK;
    if (act_r == bba_pkg::ACT_ALLOC) begin
      if (req_r == 9'd0) chk_code = bba_pkg::ST_ZERO;
      else if (!tag_ok) chk_code = bba_pkg::ST_UNKNOWN;
      else if (tv) chk_code = bba_pkg::ST_IN_USE;
    end else if (!tv) begin
      chk_code = bba_pkg::ST_UNKNOWN;
    end
  end

  assign stat.chk_code   = chk_code;
  assign stat.clr_done   = (clr_w_r == WC_W'(NW - 1));
  assign stat.is_free    = (act_r == bba_pkg::ACT_FREE);
  assign stat.fits       = (len_a <= lim);
  assign stat.scan_found = big ? found_big : hit;
  assign stat.scan_fail  = room_out && !stat.scan_found;
  assign stat.mark_last  = !mk_big || (mk_cnt_r == '0);

  assign out_status      = out_status_r;
  assign out_start_unit  = out_start_r;
  assign out_block_units = out_len_r;

`ifndef ASSERT_OFF
  a_scan_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> !(stat.scan_found && stat.scan_fail))
    else $error("scan reports both found and no space");

  a_alloc_fresh_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tag_commit && (act_r == bba_pkg::ACT_ALLOC)) |-> !tv)
    else $error("allocation committed on a tag already in use");

  a_mark_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_write |-> (mk_w_r < WC_W'(NW)))
    else $error("block write beyond the bitmap");

  a_free_releases: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tag_commit && (act_r == bba_pkg::ACT_FREE)) |=> !tag_valid_r[$past(tidx)])
    else $error("freed tag still marked valid");
`endif

endmodule

/* hdl/bba_ctrl.sv */
module bba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bba_pkg::ctrl_cmd_t cmd,
  input  bba_pkg::dp_stat_t  stat
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MREAD,
    S_MWRITE,
    S_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  bba_pkg::status_t code_r, code_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.out_code  = code_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.chk_code != bba_pkg::ST_OK) begin
          code_nxt  = stat.chk_code;
          state_nxt = S_FINISH;
        end else if (stat.is_free) begin
          cmd.free_setup = 1'b1;
          state_nxt      = S_MREAD;
        end else if (!stat.fits) begin
          code_nxt  = bba_pkg::ST_NO_SPACE;
          state_nxt = S_FINISH;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_found) begin
          state_nxt = S_MREAD;
        end else if (stat.scan_fail) begin
          code_nxt  = bba_pkg::ST_NO_SPACE;
          state_nxt = S_FINISH;
        end
      end
      S_MREAD: begin
        cmd.mark_read = 1'b1;
        state_nxt     = S_MWRITE;
      end
      S_MWRITE: begin
        cmd.mark_write = 1'b1;
        if (stat.mark_last) begin
          cmd.tag_commit = 1'b1;
          code_nxt       = bba_pkg::ST_OK;
          state_nxt      = S_FINISH;
        end
      end
      S_FINISH: begin
        // result slot is free once the previous beat has gone
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      code_r      <= bba_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hdl/buddy_block_allocator_top.sv */
// Buddy-style allocator over a pool of POOL_MAX units held as a bitmap of
// 16-unit words in one memory. After reset a clearing pass writes the bitmap
// once, one word a cycle, with in_tready low; cfg writes are taken at any
// time. An allocate rounds the request up to a power of two and scans the
// bitmap one word per cycle from unit 0 until a fit is found or the pool bound
// is passed, and then writes the block word by word (one word for blocks of
// up to 16 units, size/16 words above that). A free writes its block word by
// word too, and an item rejected by its checks writes nothing. The bitmap
// memory has one read port and one write port. One item is in work at a time;
// its result sits in an output register while the next beat is taken.
module buddy_block_allocator_top #(
  parameter int POOL_MAX  = 256,
  parameter int TAG_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [3:0] tag, [12:4] request, [15:13] zero
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] status, [10:3] start_unit,
                                  // [19:11] block_units, [23:20] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data    // pool_units
);

  bba_pkg::ctrl_cmd_t cmd;
  bba_pkg::dp_stat_t  stat;
  bba_pkg::status_t   res_status;
  logic [7:0]         res_start;
  logic [8:0]         res_len;

  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  bba_datapath #(
    .POOL_MAX  (POOL_MAX),
    .TAG_COUNT (TAG_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_tuser),
    .in_tag          (in_tdata[3:0]),
    .in_request      (in_tdata[12:4]),
    .cfg_we          (cfg_valid),
    .cfg_data        (cfg_data),
    .out_status      (res_status),
    .out_start_unit  (res_start),
    .out_block_units (res_len)
  );

  // Result beat packing
  assign out_tdata = {4'b0000, res_len, res_start, 3'(res_status)};

endmodule

/* bench/tb_buddy_block_allocator_top.sv */
`timescale 1ns / 100ps

module tb_buddy_block_allocator_top;

  localparam int POOL_MAX    = 256;
  localparam int TAG_COUNT   = 16;
  localparam int NUM_DIR     = 26;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 110;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    bba_pkg::status_t status;
    logic [7:0]       start_unit;
    logic [8:0]       block_units;
  } alloc_result_t;

  typedef struct packed {
    logic          act;
    logic [3:0]    tag;
    logic [8:0]    req;
    logic          fixed;  // expectation typed into the row
    alloc_result_t want;
  } stim_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data   = '0;

  // Allocator shadow state
  logic        unit_busy [POOL_MAX];
  logic        tag_held  [TAG_COUNT];
  logic [7:0]  tag_base  [TAG_COUNT];
  logic [3:0]  tag_log   [TAG_COUNT];
  logic [8:0]  pool_reg;

  alloc_result_t pending_results [$];
  stim_row_t     directed_rows [NUM_DIR];
  logic [8:0]    pool_plan [NUM_PHASES];

  int  mismatches  = 0;
  int  items_sent  = 0;
  int  grants      = 0;
  int  releases    = 0;
  int  rejects     = 0;
  int  cycle_count = 0;
  bit  quiet       = 1'b0;

  buddy_block_allocator_top #(
    .POOL_MAX  (POOL_MAX),
    .TAG_COUNT (TAG_COUNT)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Expected outcome of one allocate or free; updates the shadow state
  function automatic alloc_result_t buddy_outcome(logic act, logic [3:0] tag,
                                                  logic [8:0] req);
    alloc_result_t r;
    int lg, len, lim, pos, k;
    bit fit;
    r.status      = bba_pkg::ST_OK;
    r.start_unit  = '0;
    r.block_units = '0;
    if (act == bba_pkg::ACT_ALLOC) begin
      if (req == 0) begin
        r.status = bba_pkg::ST_ZERO;
      end else if (tag >= TAG_COUNT) begin
        r.status = bba_pkg::ST_UNKNOWN;
      end else if (tag_held[tag]) begin
        r.status = bba_pkg::ST_IN_USE;
      end else begin
        lg = 0;
        while ((1 << lg) < req) lg++;
        len = 1 << lg;
        lim = (pool_reg > POOL_MAX) ? POOL_MAX : pool_reg;
        r.status = bba_pkg::ST_NO_SPACE;
        // first aligned position whose whole block is free
        for (pos = 0; len <= lim && pos <= lim - len && r.status != bba_pkg::ST_OK;
             pos += len) begin
          fit = 1'b1;
          for (k = 0; k < len; k++)
            if (unit_busy[pos + k]) fit = 1'b0;
          if (fit) begin
            for (k = 0; k < len; k++) unit_busy[pos + k] = 1'b1;
            tag_held[tag] = 1'b1;
            tag_base[tag] = pos[7:0];
            tag_log[tag]  = lg[3:0];
            r.status      = bba_pkg::ST_OK;
            r.start_unit  = pos[7:0];
            r.block_units = len[8:0];
          end
        end
      end
    end else begin
      if (tag >= TAG_COUNT || !tag_held[tag]) begin
        r.status = bba_pkg::ST_UNKNOWN;
      end else begin
        len = 1 << tag_log[tag];
        for (k = 0; k < len; k++)
          if (tag_base[tag] + k < POOL_MAX) unit_busy[tag_base[tag] + k] = 1'b0;
        tag_held[tag] = 1'b0;
        r.start_unit  = tag_base[tag];
        r.block_units = len[8:0];
      end
    end
    if (r.status != bba_pkg::ST_OK) rejects++;
    else if (act == bba_pkg::ACT_ALLOC) grants++;
    else releases++;
    return r;
  endfunction

  // Present one beat at a falling edge, record its outcome once accepted
  task automatic send_item(logic act, logic [3:0] tag, logic [8:0] req,
                           logic fixed, alloc_result_t want);
    alloc_result_t got;
    quiet = (items_sent >= 500 && items_sent < 760);
    if (!quiet && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, req, tag};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    got = buddy_outcome(act, tag, req);
    pending_results.push_back(fixed ? want : got);
    items_sent++;
    @(negedge clk);
  endtask

  // Mostly well-formed allocate/free traffic, some noise
  task automatic send_random();
    logic       act;
    logic [3:0] tag;
    logic [8:0] req;
    int         pick, tries;
    pick = $urandom_range(99);
    tag  = 4'($urandom_range(15));
    req  = 9'($urandom_range(511));
    if (pick < 50) begin
      act = bba_pkg::ACT_ALLOC;
      for (tries = 0; tries < 8 && tag_held[tag]; tries++) tag = 4'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 60)      req = 9'($urandom_range(1, 16));
      else if (pick < 85) req = 9'($urandom_range(17, 64));
      else if (pick < 96) req = 9'($urandom_range(65, 256));
      else                req = 9'($urandom_range(257, 511));
    end else if (pick < 90) begin
      act = bba_pkg::ACT_FREE;
      for (tries = 0; tries < 8 && !tag_held[tag]; tries++) tag = 4'($urandom_range(15));
    end else begin
      act = 1'($urandom_range(1));
      if ($urandom_range(1)) req = '0;
    end
    send_item(act, tag, req, 1'b0, '0);
  endtask

  // Result sink backpressure
  always @(negedge clk) begin
    out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 16);
  end

  // Result checker
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[2:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[2:0]);
          mismatches++;
        end
        if (out_tdata[10:3] !== want.start_unit) begin
          $error("start_unit: expected %0d, got %0d", want.start_unit, out_tdata[10:3]);
          mismatches++;
        end
        if (out_tdata[19:11] !== want.block_units) begin
          $error("block_units: expected %0d, got %0d", want.block_units,
                 out_tdata[19:11]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    foreach (unit_busy[i]) unit_busy[i] = 1'b0;
    foreach (tag_held[i]) begin
      tag_held[i] = 1'b0;
      tag_base[i] = '0;
      tag_log[i]  = '0;
    end
    pool_reg = 9'd256;

    // Directed rows, run on the reset pool size
    directed_rows = '{
      '{bba_pkg::ACT_ALLOC, 4'd0,  9'd0,   1'b1, '{bba_pkg::ST_ZERO,     8'd0, 9'd0}},
      '{bba_pkg::ACT_ALLOC, 4'd0,  9'd1,   1'b1, '{bba_pkg::ST_OK,       8'd0, 9'd1}},
      '{bba_pkg::ACT_ALLOC, 4'd0,  9'd5,   1'b1, '{bba_pkg::ST_IN_USE,   8'd0, 9'd0}},
      '{bba_pkg::ACT_FREE,  4'd1,  9'd0,   1'b1, '{bba_pkg::ST_UNKNOWN,  8'd0, 9'd0}},
      '{bba_pkg::ACT_ALLOC, 4'd1,  9'd256, 1'b1, '{bba_pkg::ST_NO_SPACE, 8'd0, 9'd0}},
      '{bba_pkg::ACT_ALLOC, 4'd2,  9'd511, 1'b1, '{bba_pkg::ST_NO_SPACE, 8'd0, 9'd0}},
      '{bba_pkg::ACT_ALLOC, 4'd3,  9'd3,   1'b0, '0},
      '{bba_pkg::ACT_ALLOC, 4'd4,  9'd16,  1'b0, '0},
      '{bba_pkg::ACT_ALLOC, 4'd5,  9'd17,  1'b0, '0},
      '{bba_pkg::ACT_ALLOC, 4'd6,  9'd2,   1'b0, '0},
      '{bba_pkg::ACT_ALLOC, 4'd7,  9'd128, 1'b0, '0},
      '{bba_pkg::ACT_ALLOC, 4'd8,  9'd64,  1'b0, '0},
      '{bba_pkg::ACT_ALLOC, 4'd9,  9'd64,  1'b0, '0},
      '{bba_pkg::ACT_FREE,  4'd0,  9'd0,   1'b1, '{bba_pkg::ST_OK,       8'd0, 9'd1}},
      '{bba_pkg::ACT_FREE,  4'd9,  9'd0,   1'b1, '{bba_pkg::ST_UNKNOWN,  8'd0, 9'd0}},
      '{bba_pkg::ACT_ALLOC, 4'd10, 9'd1,   1'b0, '0},
      '{bba_pkg::ACT_FREE,  4'd7,  9'd0,   1'b0, '0},
      '{bba_pkg::ACT_FREE,  4'd8,  9'd0,   1'b0, '0},
      '{bba_pkg::ACT_FREE,  4'd5,  9'd0,   1'b0, '0},
      '{bba_pkg::ACT_FREE,  4'd4,  9'd0,   1'b0, '0},
      '{bba_pkg::ACT_FREE,  4'd3,  9'd0,   1'b0, '0},
      '{bba_pkg::ACT_FREE,  4'd6,  9'd0,   1'b0, '0},
      '{bba_pkg::ACT_FREE,  4'd10, 9'd0,   1'b0, '0},
      '{bba_pkg::ACT_ALLOC, 4'd15, 9'd256, 1'b0, '0},
      '{bba_pkg::ACT_ALLOC, 4'd14, 9'd1,   1'b1, '{bba_pkg::ST_NO_SPACE, 8'd0, 9'd0}},
      '{bba_pkg::ACT_FREE,  4'd15, 9'h1ff, 1'b1, '{bba_pkg::ST_OK,       8'd0, 9'd256}}
    };

    // Pool sizes per phase: zero, one, saturating and odd bounds
    pool_plan = '{9'd0, 9'd1, 9'd511, 9'd2, 9'd300, 9'd100,
                  9'd37, 9'd256, 9'd128, 9'd64, 9'd17, 9'd0};
    pool_plan[NUM_PHASES-1] = 9'($urandom_range(1, 256));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].act, directed_rows[i].tag, directed_rows[i].req,
                directed_rows[i].fixed, directed_rows[i].want);
    in_tvalid <= 1'b0;

    // Random phases; pool changes only once the block has drained
    foreach (pool_plan[p]) begin
      while (pending_results.size() != 0) @(posedge clk);
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_data  <= pool_plan[p];
      do @(posedge clk); while (!cfg_ready);
      pool_reg = pool_plan[p];
      @(negedge clk);
      cfg_valid <= 1'b0;
      repeat (PHASE_ITEMS) send_random();
      in_tvalid <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("covered %0d items over %0d pool sizes (0, 1 and saturated among them)",
             items_sent, NUM_PHASES + 1);
    $display("outcomes: %0d blocks granted, %0d released, %0d rejected",
             grants, releases, rejects);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/bba_pkg.sv
hdl/bba_datapath.sv
hdl/bba_ctrl.sv
hdl/buddy_block_allocator_top.sv
bench/tb_buddy_block_allocator_top.sv
